[sv/rpi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_pkg
// Shared types, codes and arithmetic helpers of the radial profile integrator.
// ----------------------------------------------------------------------------
package rpi_pkg;

    localparam int MAX_POINTS_DEFAULT = 1024;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int SAMPLE_W  = 32;
    localparam int VALUE_W   = 48;
    localparam int WIDE_W    = 64;
    localparam int PROD_W    = 128;
    localparam int THETA_W   = 48;

    localparam logic [CFG_W-1:0]   CFG_RESET = 32'h0001_0000;
    localparam logic [WIDE_W-1:0]  MAX48     = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [WIDE_W-1:0]  MAX64     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_DENS = 2'd1,
        OP_MASS = 2'd2,
        OP_POT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_FEW  = 2'd1,
        STS_FULL = 2'd2,
        STS_SAT  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP   = 2'd0,
        CFG_INV    = 2'd1,
        CFG_MSCALE = 2'd2,
        CFG_PSCALE = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_NONE, ST_CAPTURE, ST_FULL, ST_ZERO, ST_THETA, ST_W, ST_INC1, ST_MASS,
        ST_DIV, ST_INC2, ST_COMMIT, ST_FEW, ST_POS, ST_RDA, ST_RDB, ST_LATB,
        ST_INTERP, ST_SCALE, ST_QDONE, ST_EMIT
    } t_step;

    typedef enum logic [2:0] {
        SH_0, SH_8, SH_16, SH_17, SH_32
    } t_shift;

    typedef struct packed {
        t_step step;
        logic  start;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic zero_pt;
        logic full;
        logic few;
        logic in_range;
        logic is_pot;
        logic mul_done;
        logic div_done;
    } t_dp_stat;

    typedef struct packed {
        logic [WIDE_W-1:0] r;
        logic              sat;
    } t_mulres;

    // Takes a full product, drops the fraction bits and saturates to the limit.
    function automatic t_mulres mul_post(input logic [PROD_W-1:0] p, input t_shift sh,
                                         input logic lim48);
        logic [WIDE_W-1:0] r;
        logic              over;
        t_mulres           res;
        case (sh)
            SH_0: begin
                r    = p[63:0];
                over = |p[127:64];
            end
            SH_8: begin
                r    = p[71:8];
                over = |p[127:72];
            end
            SH_16: begin
                r    = p[79:16];
                over = |p[127:80];
            end
            SH_17: begin
                r    = p[80:17];
                over = |p[127:81];
            end
            SH_32: begin
                r    = p[95:32];
                over = |p[127:96];
            end
            default: begin
                r    = p[63:0];
                over = |p[127:64];
            end
        endcase
        if (lim48 && (|r[63:48])) begin
            over = 1'b1;
        end
        if (over) begin
            r = lim48 ? MAX48 : MAX64;
        end
        res.r   = r;
        res.sat = over;
        return res;
    endfunction

endpackage

[sv/radial_profile_integrate_interp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_profile_integrate_interp
// Cumulative trapezoid mass and potential tables with interpolating queries.
// ----------------------------------------------------------------------------
// The block handles one item at a time. A load makes five passes through the
// shared 64x64 multiplier, which uses a single 32x32 multiplier, and one 64-step
// radix-2 divide, besides capture, decode, commit and issue; a first point, a
// full table or a short table answers without them. A query makes one multiply
// for the position, two reads of the table memory, one multiply to interpolate
// unless the radius clamps, and one more to scale a potential. An item waits in
// its issue step while an earlier result still waits on the output.
// A new item is taken while the previous result still waits on the output. The
// tables hold MAX_POINTS entries and need no clearing after reset.
module radial_profile_integrate_interp #(
    parameter int MAX_POINTS = rpi_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rpi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpi_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_op,
    input  logic [31:0]                   i_sample_or_radius,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [47:0]                   o_value,
    output logic [1:0]                    o_status
);

    rpi_pkg::t_cmd     w_cmd;
    rpi_pkg::t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    rpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    rpi_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_op               (i_op),
        .i_sample_or_radius (i_sample_or_radius),
        .i_restart          (i_restart),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .o_value            (o_value),
        .o_status           (o_status)
    );

endmodule

[sv/rpi_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_mul
// Multi-cycle 64x64 multiplier built from one 32x32 multiplier, four partials.
// ----------------------------------------------------------------------------
module rpi_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rpi_pkg::WIDE_W-1:0]  i_a,
    input  logic [rpi_pkg::WIDE_W-1:0]  i_b,
    output logic                        o_done,
    output logic [rpi_pkg::PROD_W-1:0]  o_prod
);

    logic [rpi_pkg::WIDE_W-1:0] r_a;
    logic [rpi_pkg::WIDE_W-1:0] r_b;
    logic [rpi_pkg::PROD_W-1:0] r_acc;
    logic [63:0]                r_pp;
    logic [2:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [1:0]                 w_part;
    logic [31:0]                w_ah;
    logic [31:0]                w_bh;
    logic [6:0]                 w_shamt;

    // Even counts form a partial product, odd counts add it in.
    assign w_part = r_cnt[2:1];
    assign w_ah   = w_part[1] ? r_a[63:32] : r_a[31:0];
    assign w_bh   = w_part[0] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        case (w_part)
            2'd0:    w_shamt = 7'd0;
            2'd3:    w_shamt = 7'd64;
            default: w_shamt = 7'd32;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (!r_cnt[0]) begin
                r_pp <= w_ah * w_bh;
            end else begin
                r_acc <= r_acc + ({64'd0, r_pp} << w_shamt);
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[sv/rpi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_div
// Radix-2 restoring divider, 64-bit dividend by 48-bit divisor, 64 steps.
// ----------------------------------------------------------------------------
module rpi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rpi_pkg::WIDE_W-1:0]  i_num,
    input  logic [rpi_pkg::THETA_W-1:0] i_den,
    output logic                        o_done,
    output logic [rpi_pkg::WIDE_W-1:0]  o_quot
);

    logic [rpi_pkg::WIDE_W-1:0]  r_nq;
    logic [rpi_pkg::THETA_W-1:0] r_rem;
    logic [rpi_pkg::THETA_W-1:0] r_den;
    logic [5:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [rpi_pkg::THETA_W:0]   w_trial;
    logic                        w_ge;

    // The dividend shifts out at the top while quotient bits shift in below.
    // A zero divisor yields all ones, which the caller saturates.
    assign w_trial = {r_rem, r_nq[63]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_nq  <= {r_nq[62:0], w_ge};
            r_rem <= w_ge ? rpi_pkg::THETA_W'(w_trial - {1'b0, r_den})
                          : w_trial[rpi_pkg::THETA_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq;

endmodule

[sv/rpi_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_datapath
// Tables, integrals, configuration and the shared multiplier and divider.
// ----------------------------------------------------------------------------
module rpi_datapath #(
    parameter int MAX_POINTS = rpi_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [rpi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rpi_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [1:0]                     i_op,
    input  logic [rpi_pkg::SAMPLE_W-1:0]   i_sample_or_radius,
    input  logic                           i_restart,
    input  rpi_pkg::t_cmd                  i_cmd,
    output rpi_pkg::t_dp_stat              o_stat,
    output logic [rpi_pkg::VALUE_W-1:0]    o_value,
    output logic [1:0]                     o_status
);

    localparam int PTS_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_POINTS);

    // Configuration and integration state.
    logic [rpi_pkg::CFG_W-1:0]   r_step;
    logic [rpi_pkg::CFG_W-1:0]   r_inv;
    logic [rpi_pkg::CFG_W-1:0]   r_mscale;
    logic [rpi_pkg::CFG_W-1:0]   r_pscale;
    logic [PTS_W-1:0]            r_points;
    logic [rpi_pkg::WIDE_W-1:0]  r_di;
    logic [rpi_pkg::WIDE_W-1:0]  r_pi;
    logic [rpi_pkg::VALUE_W-1:0] r_prev_w;
    logic [rpi_pkg::VALUE_W-1:0] r_prev_q;

    // Working registers of the current item.
    rpi_pkg::t_op                r_op;
    logic [rpi_pkg::SAMPLE_W-1:0] r_sample;
    logic                        r_restart;
    logic                        r_sat;
    logic [rpi_pkg::THETA_W-1:0] r_theta;
    logic [rpi_pkg::VALUE_W-1:0] r_w;
    logic [rpi_pkg::VALUE_W-1:0] r_mass;
    logic [rpi_pkg::VALUE_W-1:0] r_q;
    logic [31:0]                 r_idx;
    logic [31:0]                 r_frac;
    logic [rpi_pkg::VALUE_W-1:0] r_a;
    logic [rpi_pkg::VALUE_W-1:0] r_b;
    logic [rpi_pkg::VALUE_W-1:0] r_res_value;
    rpi_pkg::t_status            r_res_status;
    logic [rpi_pkg::VALUE_W-1:0] r_value;
    logic [1:0]                  r_status;

    // Tables.
    logic [rpi_pkg::SAMPLE_W-1:0] r_dens_mem [MAX_POINTS];
    logic [rpi_pkg::VALUE_W-1:0]  r_mass_mem [MAX_POINTS];
    logic [rpi_pkg::VALUE_W-1:0]  r_pot_mem  [MAX_POINTS];
    logic [rpi_pkg::SAMPLE_W-1:0] r_rd_dens;
    logic [rpi_pkg::VALUE_W-1:0]  r_rd_mass;
    logic [rpi_pkg::VALUE_W-1:0]  r_rd_pot;

    logic [PTS_W-1:0]            w_i;
    logic [PTS_W-1:0]            w_last;
    logic                        w_lt;
    logic [ADDR_W-1:0]           w_idx_lo;
    logic [ADDR_W-1:0]           w_rd_addr;
    logic [ADDR_W-1:0]           w_wr_addr;
    logic                        w_we;
    logic [rpi_pkg::SAMPLE_W-1:0] w_wr_dens;
    logic [rpi_pkg::VALUE_W-1:0] w_wr_mass;
    logic [rpi_pkg::VALUE_W-1:0] w_wr_pot;
    logic                        w_pot_over;
    logic [rpi_pkg::VALUE_W-1:0] w_rd_sel;
    logic [rpi_pkg::VALUE_W-1:0] w_diff;
    logic                        w_b_ge;

    logic                        w_mul_start;
    logic [rpi_pkg::WIDE_W-1:0]  w_mul_a;
    logic [rpi_pkg::WIDE_W-1:0]  w_mul_b;
    rpi_pkg::t_shift             w_sh;
    logic                        w_lim48;
    logic                        w_mul_done;
    logic [rpi_pkg::PROD_W-1:0]  w_prod;
    rpi_pkg::t_mulres            w_mres;
    logic [rpi_pkg::WIDE_W:0]    w_acc_sum;
    logic [rpi_pkg::WIDE_W-1:0]  w_acc_sat;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [rpi_pkg::WIDE_W-1:0]  w_quot;

    assign w_i      = r_restart ? '0 : r_points;
    assign w_last   = r_points - 1'b1;
    assign w_lt     = r_idx < 32'(w_last);
    assign w_idx_lo = r_idx[ADDR_W-1:0];

    // The second read of a query fetches the upper neighbor.
    always_comb begin
        if (i_cmd.step == rpi_pkg::ST_RDB) begin
            w_rd_addr = w_lt ? ADDR_W'(w_idx_lo + 1'b1) : w_last[ADDR_W-1:0];
        end else begin
            w_rd_addr = w_lt ? w_idx_lo : w_last[ADDR_W-1:0];
        end
    end

    assign w_pot_over = |r_pi[63:48];
    assign w_wr_addr  = w_i[ADDR_W-1:0];
    assign w_we       = (i_cmd.step == rpi_pkg::ST_ZERO) || (i_cmd.step == rpi_pkg::ST_COMMIT);
    assign w_wr_dens  = r_sample;
    assign w_wr_mass  = (i_cmd.step == rpi_pkg::ST_ZERO) ? '0 : r_mass;
    assign w_wr_pot   = (i_cmd.step == rpi_pkg::ST_ZERO) ? '0 :
                        (w_pot_over ? rpi_pkg::MAX48[47:0] : r_pi[47:0]);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_dens_mem[w_wr_addr] <= w_wr_dens;
            r_mass_mem[w_wr_addr] <= w_wr_mass;
            r_pot_mem[w_wr_addr]  <= w_wr_pot;
        end
        r_rd_dens <= r_dens_mem[w_rd_addr];
        r_rd_mass <= r_mass_mem[w_rd_addr];
        r_rd_pot  <= r_pot_mem[w_rd_addr];
    end

    always_comb begin
        case (r_op)
            rpi_pkg::OP_DENS: w_rd_sel = {8'd0, r_rd_dens, 8'd0};
            rpi_pkg::OP_MASS: w_rd_sel = r_rd_mass;
            default:          w_rd_sel = r_rd_pot;
        endcase
    end

    assign w_b_ge = r_b >= r_a;
    assign w_diff = w_b_ge ? (r_b - r_a) : (r_a - r_b);

    // Operand and scaling selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        w_sh    = rpi_pkg::SH_0;
        w_lim48 = 1'b0;
        case (i_cmd.step)
            rpi_pkg::ST_THETA: begin
                w_mul_a = 64'(w_i);
                w_mul_b = 64'(r_step);
            end
            rpi_pkg::ST_W: begin
                w_mul_a = 64'(r_sample);
                w_mul_b = 64'(r_theta);
                w_sh    = rpi_pkg::SH_8;
                w_lim48 = 1'b1;
            end
            rpi_pkg::ST_INC1: begin
                w_mul_a = 64'(r_step);
                w_mul_b = 64'(r_w) + 64'(r_prev_w);
                w_sh    = rpi_pkg::SH_17;
            end
            rpi_pkg::ST_MASS: begin
                w_mul_a = 64'(r_mscale);
                w_mul_b = r_di;
                w_sh    = rpi_pkg::SH_16;
                w_lim48 = 1'b1;
            end
            rpi_pkg::ST_INC2: begin
                w_mul_a = 64'(r_step);
                w_mul_b = 64'(r_q) + 64'(r_prev_q);
                w_sh    = rpi_pkg::SH_17;
            end
            rpi_pkg::ST_POS: begin
                w_mul_a = 64'(r_sample);
                w_mul_b = 64'(r_inv);
            end
            rpi_pkg::ST_INTERP: begin
                w_mul_a = 64'(w_diff);
                w_mul_b = 64'(r_frac);
                w_sh    = rpi_pkg::SH_32;
            end
            rpi_pkg::ST_SCALE: begin
                w_mul_a = 64'(r_a);
                w_mul_b = 64'(r_pscale);
                w_sh    = rpi_pkg::SH_16;
                w_lim48 = 1'b1;
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    assign w_mul_start = i_cmd.start && (i_cmd.step inside {rpi_pkg::ST_THETA,
                         rpi_pkg::ST_W, rpi_pkg::ST_INC1, rpi_pkg::ST_MASS,
                         rpi_pkg::ST_INC2, rpi_pkg::ST_POS, rpi_pkg::ST_INTERP,
                         rpi_pkg::ST_SCALE});
    assign w_div_start = i_cmd.start && (i_cmd.step == rpi_pkg::ST_DIV);

    rpi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    rpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_mass, 16'd0}),
        .i_den   (r_theta),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_mres = rpi_pkg::mul_post(w_prod, w_sh, w_lim48);

    // Saturating accumulate used by both trapezoid integrals.
    always_comb begin
        if (i_cmd.step == rpi_pkg::ST_INC1) begin
            w_acc_sum = {1'b0, r_di} + {1'b0, w_mres.r};
        end else begin
            w_acc_sum = {1'b0, r_pi} + {1'b0, w_mres.r};
        end
        w_acc_sat = w_acc_sum[64] ? rpi_pkg::MAX64 : w_acc_sum[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= rpi_pkg::CFG_RESET;
            r_inv    <= rpi_pkg::CFG_RESET;
            r_mscale <= rpi_pkg::CFG_RESET;
            r_pscale <= rpi_pkg::CFG_RESET;
            r_points <= '0;
            r_di     <= '0;
            r_pi     <= '0;
            r_prev_w <= '0;
            r_prev_q <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (rpi_pkg::t_cfg_idx'(i_cfg_index))
                    rpi_pkg::CFG_STEP:   r_step   <= i_cfg_data;
                    rpi_pkg::CFG_INV:    r_inv    <= i_cfg_data;
                    rpi_pkg::CFG_MSCALE: r_mscale <= i_cfg_data;
                    rpi_pkg::CFG_PSCALE: r_pscale <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.step)
                rpi_pkg::ST_ZERO: begin
                    r_points <= PTS_W'(1);
                    r_di     <= '0;
                    r_pi     <= '0;
                    r_prev_w <= '0;
                    r_prev_q <= '0;
                end
                rpi_pkg::ST_INC1: begin
                    if (w_mul_done) begin
                        r_di <= w_acc_sat;
                    end
                end
                rpi_pkg::ST_INC2: begin
                    if (w_mul_done) begin
                        r_pi <= w_acc_sat;
                    end
                end
                rpi_pkg::ST_COMMIT: begin
                    r_points <= w_i + 1'b1;
                    r_prev_w <= r_w;
                    r_prev_q <= r_q;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.step)
            rpi_pkg::ST_CAPTURE: begin
                r_op      <= rpi_pkg::t_op'(i_op);
                r_sample  <= i_sample_or_radius;
                r_restart <= i_restart;
                r_sat     <= 1'b0;
            end
            rpi_pkg::ST_FULL: begin
                r_res_value  <= '0;
                r_res_status <= rpi_pkg::STS_FULL;
            end
            rpi_pkg::ST_FEW: begin
                r_res_value  <= '0;
                r_res_status <= rpi_pkg::STS_FEW;
            end
            rpi_pkg::ST_ZERO: begin
                r_res_value  <= '0;
                r_res_status <= rpi_pkg::STS_OK;
            end
            rpi_pkg::ST_THETA: begin
                if (w_mul_done) begin
                    r_theta <= w_mres.r[rpi_pkg::THETA_W-1:0];
                end
            end
            rpi_pkg::ST_W: begin
                if (w_mul_done) begin
                    r_w   <= w_mres.r[47:0];
                    r_sat <= r_sat | w_mres.sat;
                end
            end
            rpi_pkg::ST_INC1, rpi_pkg::ST_INC2: begin
                if (w_mul_done) begin
                    r_sat <= r_sat | w_mres.sat | w_acc_sum[64];
                end
            end
            rpi_pkg::ST_MASS: begin
                if (w_mul_done) begin
                    r_mass <= w_mres.r[47:0];
                    r_sat  <= r_sat | w_mres.sat;
                end
            end
            rpi_pkg::ST_DIV: begin
                if (w_div_done) begin
                    if (|w_quot[63:48]) begin
                        r_q   <= rpi_pkg::MAX48[47:0];
                        r_sat <= 1'b1;
                    end else begin
                        r_q <= w_quot[47:0];
                    end
                end
            end
            rpi_pkg::ST_COMMIT: begin
                r_res_value  <= r_mass;
                r_res_status <= (r_sat || w_pot_over) ? rpi_pkg::STS_SAT : rpi_pkg::STS_OK;
            end
            rpi_pkg::ST_POS: begin
                if (w_mul_done) begin
                    r_idx  <= w_mres.r[63:32];
                    r_frac <= w_mres.r[31:0];
                end
            end
            rpi_pkg::ST_RDB: begin
                r_a <= w_rd_sel;
            end
            rpi_pkg::ST_LATB: begin
                r_b <= w_rd_sel;
            end
            rpi_pkg::ST_INTERP: begin
                if (w_mul_done) begin
                    r_a <= w_b_ge ? (r_a + w_mres.r[47:0]) : (r_a - w_mres.r[47:0]);
                end
            end
            rpi_pkg::ST_SCALE: begin
                if (w_mul_done) begin
                    r_res_value  <= w_mres.r[47:0];
                    r_res_status <= w_mres.sat ? rpi_pkg::STS_SAT : rpi_pkg::STS_OK;
                end
            end
            rpi_pkg::ST_QDONE: begin
                r_res_value  <= r_a;
                r_res_status <= rpi_pkg::STS_OK;
            end
            rpi_pkg::ST_EMIT: begin
                r_value  <= r_res_value;
                r_status <= r_res_status;
            end
            default: ;
        endcase
    end

    assign o_stat.is_load  = r_op == rpi_pkg::OP_LOAD;
    assign o_stat.zero_pt  = w_i == '0;
    assign o_stat.full     = w_i >= PTS_W'(MAX_POINTS);
    assign o_stat.few      = r_points < PTS_W'(2);
    assign o_stat.in_range = w_lt;
    assign o_stat.is_pot   = r_op == rpi_pkg::OP_POT;
    assign o_stat.mul_done = w_mul_done;
    assign o_stat.div_done = w_div_done;

    assign o_value  = r_value;
    assign o_status = r_status;

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_done && w_div_done))
        else $error("multiplier and divider finished in the same cycle");

    a_commit_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == rpi_pkg::ST_COMMIT) |-> (w_i < PTS_W'(MAX_POINTS)))
        else $error("load committed into a full table");

    a_commit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == rpi_pkg::ST_COMMIT) |=> (r_points == $past(w_i) + 1'b1))
        else $error("point count did not advance after a load");

    a_query_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == rpi_pkg::ST_RDA) |-> (r_points >= PTS_W'(2)))
        else $error("table read for a query with fewer than two points");

endmodule

[sv/rpi_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_ctrl
// Sequencer for loads and queries, input and output handshakes.
// ----------------------------------------------------------------------------
module rpi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rpi_pkg::t_dp_stat i_stat,
    output rpi_pkg::t_cmd     o_cmd
);

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_DECIDE = 20'h00002,
        S_FULL   = 20'h00004,
        S_ZERO   = 20'h00008,
        S_THETA  = 20'h00010,
        S_W      = 20'h00020,
        S_INC1   = 20'h00040,
        S_MASS   = 20'h00080,
        S_DIV    = 20'h00100,
        S_INC2   = 20'h00200,
        S_COMMIT = 20'h00400,
        S_FEW    = 20'h00800,
        S_POS    = 20'h01000,
        S_RDA    = 20'h02000,
        S_RDB    = 20'h04000,
        S_LATB   = 20'h08000,
        S_INTERP = 20'h10000,
        S_SCALE  = 20'h20000,
        S_QDONE  = 20'h40000,
        S_EMIT   = 20'h80000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_first;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd.step  = rpi_pkg::ST_NONE;
        o_cmd.start = r_first;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.step = rpi_pkg::ST_CAPTURE;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.is_load) begin
                    if (i_stat.zero_pt) begin
                        n_state = S_ZERO;
                    end else if (i_stat.full) begin
                        n_state = S_FULL;
                    end else begin
                        n_state = S_THETA;
                    end
                end else begin
                    n_state = i_stat.few ? S_FEW : S_POS;
                end
            end
            S_FULL: begin
                o_cmd.step = rpi_pkg::ST_FULL;
                n_state    = S_EMIT;
            end
            S_ZERO: begin
                o_cmd.step = rpi_pkg::ST_ZERO;
                n_state    = S_EMIT;
            end
            S_FEW: begin
                o_cmd.step = rpi_pkg::ST_FEW;
                n_state    = S_EMIT;
            end
            S_THETA: begin
                o_cmd.step = rpi_pkg::ST_THETA;
                if (i_stat.mul_done) n_state = S_W;
            end
            S_W: begin
                o_cmd.step = rpi_pkg::ST_W;
                if (i_stat.mul_done) n_state = S_INC1;
            end
            S_INC1: begin
                o_cmd.step = rpi_pkg::ST_INC1;
                if (i_stat.mul_done) n_state = S_MASS;
            end
            S_MASS: begin
                o_cmd.step = rpi_pkg::ST_MASS;
                if (i_stat.mul_done) n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = rpi_pkg::ST_DIV;
                if (i_stat.div_done) n_state = S_INC2;
            end
            S_INC2: begin
                o_cmd.step = rpi_pkg::ST_INC2;
                if (i_stat.mul_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.step = rpi_pkg::ST_COMMIT;
                n_state    = S_EMIT;
            end
            S_POS: begin
                o_cmd.step = rpi_pkg::ST_POS;
                if (i_stat.mul_done) n_state = S_RDA;
            end
            S_RDA: begin
                o_cmd.step = rpi_pkg::ST_RDA;
                n_state    = S_RDB;
            end
            S_RDB: begin
                o_cmd.step = rpi_pkg::ST_RDB;
                n_state    = S_LATB;
            end
            S_LATB: begin
                o_cmd.step = rpi_pkg::ST_LATB;
                if (i_stat.in_range) begin
                    n_state = S_INTERP;
                end else begin
                    n_state = i_stat.is_pot ? S_SCALE : S_QDONE;
                end
            end
            S_INTERP: begin
                o_cmd.step = rpi_pkg::ST_INTERP;
                if (i_stat.mul_done) n_state = i_stat.is_pot ? S_SCALE : S_QDONE;
            end
            S_SCALE: begin
                o_cmd.step = rpi_pkg::ST_SCALE;
                if (i_stat.mul_done) n_state = S_EMIT;
            end
            S_QDONE: begin
                o_cmd.step = rpi_pkg::ST_QDONE;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    o_cmd.step = rpi_pkg::ST_EMIT;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.step == rpi_pkg::ST_EMIT) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_state != r_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step == rpi_pkg::ST_EMIT) |-> (!r_out_valid || i_out_ready))
        else $error("result issued over an item not yet taken");

    a_capture_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECIDE))
        else $error("accepted item did not reach decode");

    a_mul_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !i_stat.mul_done)
        else $error("multiplier finished during a divide");

endmodule
